[rtl/core/pnc_pkg.sv]
// Shared constants, operation codes and controller/datapath interface types.
package pnc_pkg;

   localparam int OP_W          = 3;
   localparam int INDEX_W       = 8;
   localparam int COLOR_W       = 8;
   localparam int ENT_W         = 3 * COLOR_W;
   localparam int COUNT_W       = 9;
   localparam int SUM_W         = 18;
   localparam int DIST_W        = 9;
   localparam int DEFAULT_DEPTH = 256;

   localparam logic [OP_W-1:0] OP_SET     = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
   localparam logic [OP_W-1:0] OP_NEAREST = 3'd3;
   localparam logic [OP_W-1:0] OP_EXACT   = 3'd4;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_issue;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic search;
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
   } status_type;

endpackage

[rtl/core/pnc_ram.sv]
// Generic single write port RAM with registered read.
module pnc_ram #(
   parameter int WIDTH = pnc_pkg::ENT_W,
   parameter int DEPTH = pnc_pkg::DEFAULT_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/pnc_isqrt.sv]
// Pipelined floor square root, one result bit per stage, with a tag carried alongside.
module pnc_isqrt #(
   parameter int TAG_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [pnc_pkg::SUM_W-1:0]  in_value,
   input  logic [TAG_W-1:0]           in_tag,
   output logic                       out_valid,
   output logic [pnc_pkg::DIST_W-1:0] out_root,
   output logic [TAG_W-1:0]           out_tag,
   output logic                       busy
);
   import pnc_pkg::*;

   localparam int STEPS  = (SUM_W + 1) / 2;
   localparam int WORK_W = SUM_W + 1;

   logic [WORK_W-1:0] v_ff     [STEPS];
   logic [WORK_W-1:0] res_ff   [STEPS];
   logic [WORK_W-1:0] v_in     [STEPS];
   logic [WORK_W-1:0] res_in   [STEPS];
   logic [WORK_W-1:0] v_prev   [STEPS];
   logic [WORK_W-1:0] res_prev [STEPS];
   logic [WORK_W-1:0] trial    [STEPS];
   logic [STEPS-1:0]  take;
   logic [TAG_W-1:0]  tag_ff   [STEPS];
   logic [STEPS-1:0]  vld_ff;
   logic [STEPS-1:0]  vld_in;

   function automatic logic [WORK_W-1:0] stage_bit(int k);
      return WORK_W'(1) << (2 * (STEPS - 1 - k));
   endfunction

   always_comb begin
      v_prev[0]   = WORK_W'(in_value);
      res_prev[0] = '0;
      for (int k = 1; k < STEPS; k++) begin
         v_prev[k]   = v_ff[k-1];
         res_prev[k] = res_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         trial[k]  = res_prev[k] + stage_bit(k);
         take[k]   = (v_prev[k] >= trial[k]);
         v_in[k]   = take[k] ? (v_prev[k] - trial[k]) : v_prev[k];
         res_in[k] = take[k] ? ((res_prev[k] >> 1) + stage_bit(k)) : (res_prev[k] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         v_ff[k]   <= v_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign vld_in = {vld_ff[STEPS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int i = 1; i < STEPS; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][DIST_W-1:0];
   assign out_tag   = tag_ff[STEPS-1];
   assign busy      = |vld_ff;

endmodule

[rtl/core/pnc_ctrl.sv]
// Sequencing state machine and response handshake.
module pnc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pnc_pkg::cmd_type    cmd,
   input  pnc_pkg::status_type status
);
   import pnc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.search && !status.count_zero) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/pnc_dpath.sv]
// Palette storage, count, scan pipeline, best-match tracking and response word.
module pnc_dpath #(
   parameter int PALETTE_DEPTH = pnc_pkg::DEFAULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pnc_pkg::cmd_type            cmd,
   output pnc_pkg::status_type         status,
   input  logic [pnc_pkg::OP_W-1:0]    req_op,
   input  logic [pnc_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [pnc_pkg::COLOR_W-1:0] req_red,
   input  logic [pnc_pkg::COLOR_W-1:0] req_green,
   input  logic [pnc_pkg::COLOR_W-1:0] req_blue,
   output logic [pnc_pkg::INDEX_W-1:0] rsp_match_index,
   output logic                        rsp_found,
   output logic [pnc_pkg::COUNT_W-1:0] rsp_color_count
);
   import pnc_pkg::*;

   localparam int AW    = $clog2(PALETTE_DEPTH);
   localparam int TAG_W = AW + 1;
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(PALETTE_DEPTH);

   // captured request word
   logic [OP_W-1:0]    op_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [ENT_W-1:0]   color_ff;

   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PALETTE_DEPTH-1:0] vld_ff, vld_in;
   logic [AW-1:0]            scan_addr_ff, scan_addr_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [AW-1:0]            res_index_ff, res_index_in;
   logic                     res_found_ff, res_found_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          is_nearest, is_exact, idx_ok;

   // scan pipeline
   logic               s0_vld_ff, s0_ent_vld_ff;
   logic [AW-1:0]      s0_idx_ff;
   logic [ENT_W-1:0]   rdata, ent;
   logic [COLOR_W-1:0] dr, dg, db;
   logic               m_vld_ff, m_eq_ff;
   logic [AW-1:0]      m_idx_ff;
   logic [2*COLOR_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic               s_vld_ff, s_eq_ff;
   logic [AW-1:0]      s_idx_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               q_valid, q_busy;
   logic [DIST_W-1:0]  q_root;
   logic [TAG_W-1:0]   q_tag;
   logic [AW-1:0]      q_idx;
   logic               q_eq;

   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         idx_ff   <= req_entry_index;
         color_ff <= {req_red, req_green, req_blue};
      end
   end

   assign is_nearest = (op_ff == OP_NEAREST);
   assign is_exact   = (op_ff == OP_EXACT);
   assign idx_ok     = ({1'b0, idx_ff} < DEPTH_C);
   assign q_idx      = q_tag[TAG_W-1:1];
   assign q_eq       = q_tag[0];

   always_comb begin
      count_in     = count_ff;
      vld_in       = vld_ff;
      scan_addr_in = scan_addr_ff;
      best_in      = best_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      if (cmd.exec) begin
         res_index_in = '0;
         res_found_in = 1'b0;
         scan_addr_in = '0;
         best_in      = '1;
         unique case (op_ff)
            OP_SET: begin
               if (idx_ok) begin
                  wr_en        = 1'b1;
                  res_found_in = 1'b1;
                  if ({1'b0, idx_ff} >= count_ff) begin
                     count_in = {1'b0, idx_ff} + COUNT_W'(1);
                  end
               end
            end
            OP_APPEND: begin
               if (count_ff < DEPTH_C) begin
                  wr_en        = 1'b1;
                  wr_addr      = count_ff[AW-1:0];
                  count_in     = count_ff + COUNT_W'(1);
                  res_found_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               vld_in       = '0;
               count_in     = '0;
               res_found_in = 1'b1;
            end
            OP_NEAREST: begin
               res_found_in = (count_ff != '0);
            end
            default: begin
            end
         endcase
      end
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (cmd.scan_issue) begin
         scan_addr_in = scan_addr_ff + AW'(1);
      end
      if (q_valid) begin
         if (is_nearest && (q_root < best_ff)) begin
            best_in      = q_root;
            res_index_in = q_idx;
         end
         if (is_exact && q_eq && !res_found_ff) begin
            res_index_in = q_idx;
            res_found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         vld_ff   <= '0;
      end else begin
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      best_ff      <= best_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
   end

   pnc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (color_ff),
      .raddr (scan_addr_ff),
      .rdata (rdata)
   );

   // entries never written since reset or clear read as zero
   assign ent = s0_ent_vld_ff ? rdata : '0;

   assign dr = (ent[3*COLOR_W-1:2*COLOR_W] > color_ff[3*COLOR_W-1:2*COLOR_W]) ?
               (ent[3*COLOR_W-1:2*COLOR_W] - color_ff[3*COLOR_W-1:2*COLOR_W]) :
               (color_ff[3*COLOR_W-1:2*COLOR_W] - ent[3*COLOR_W-1:2*COLOR_W]);
   assign dg = (ent[2*COLOR_W-1:COLOR_W] > color_ff[2*COLOR_W-1:COLOR_W]) ?
               (ent[2*COLOR_W-1:COLOR_W] - color_ff[2*COLOR_W-1:COLOR_W]) :
               (color_ff[2*COLOR_W-1:COLOR_W] - ent[2*COLOR_W-1:COLOR_W]);
   assign db = (ent[COLOR_W-1:0] > color_ff[COLOR_W-1:0]) ?
               (ent[COLOR_W-1:0] - color_ff[COLOR_W-1:0]) :
               (color_ff[COLOR_W-1:0] - ent[COLOR_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         m_vld_ff  <= 1'b0;
         s_vld_ff  <= 1'b0;
      end else begin
         s0_vld_ff <= cmd.scan_issue;
         m_vld_ff  <= s0_vld_ff;
         s_vld_ff  <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_idx_ff     <= scan_addr_ff;
      s0_ent_vld_ff <= vld_ff[scan_addr_ff];
      m_idx_ff      <= s0_idx_ff;
      m_eq_ff       <= (ent == color_ff);
      sq_r_ff       <= (2*COLOR_W)'(dr) * (2*COLOR_W)'(dr);
      sq_g_ff       <= (2*COLOR_W)'(dg) * (2*COLOR_W)'(dg);
      sq_b_ff       <= (2*COLOR_W)'(db) * (2*COLOR_W)'(db);
      s_idx_ff      <= m_idx_ff;
      s_eq_ff       <= m_eq_ff;
      sum_ff        <= SUM_W'(sq_r_ff) + SUM_W'(sq_g_ff) + SUM_W'(sq_b_ff);
   end

   pnc_isqrt #(
      .TAG_W (TAG_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_vld_ff),
      .in_value  (sum_ff),
      .in_tag    ({s_idx_ff, s_eq_ff}),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_tag   (q_tag),
      .busy      (q_busy)
   );

   always_comb begin
      status            = '0;
      status.search     = is_nearest || is_exact;
      status.count_zero = (count_ff == '0);
      status.scan_last  = (COUNT_W'(scan_addr_ff) == (count_ff - COUNT_W'(1)));
      status.pipe_busy  = s0_vld_ff || m_vld_ff || s_vld_ff || q_busy;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_index_ff <= INDEX_W'(res_index_ff);
         rsp_found_ff <= res_found_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_match_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_color_count = rsp_count_ff;

endmodule

[rtl/core/palette_nearest_color_match.sv]
// Top level of the palette nearest-color matcher.
//
//   channel  dir  handshake            word
//   req_     in   req_valid/req_ready  op, entry_index, red, green, blue
//   rsp_     out  rsp_valid/rsp_ready  match_index, found, color_count
//
// Set, append, clear and unused ops pass through the exec state to the response.
// Nearest and exact scan a non-empty palette; the scan reads one palette
// entry per cycle from the single RAM read port into a 12-stage distance pipe.
// One word in flight; the next word is taken while the response waits.
// Reset empties the palette at once through per-entry valid bits.
module palette_nearest_color_match #(
   parameter int PALETTE_DEPTH = pnc_pkg::DEFAULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pnc_pkg::OP_W-1:0]    req_op,
   input  logic [pnc_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [pnc_pkg::COLOR_W-1:0] req_red,
   input  logic [pnc_pkg::COLOR_W-1:0] req_green,
   input  logic [pnc_pkg::COLOR_W-1:0] req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pnc_pkg::INDEX_W-1:0] rsp_match_index,
   output logic                        rsp_found,
   output logic [pnc_pkg::COUNT_W-1:0] rsp_color_count
);
   import pnc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pnc_dpath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_match_index (rsp_match_index),
      .rsp_found       (rsp_found),
      .rsp_color_count (rsp_color_count)
   );

endmodule
